@@ hw/rtl/phbm_pkg.sv @@
package phbm_pkg;

    // Number of bands that carry state.
    localparam int NUM_BANDS = 8;

    localparam int BAND_W     = 3;
    localparam int TGT_W      = 18;
    localparam int LVL_W      = 17;
    localparam int AGE_W      = 16;
    localparam int DT_W       = 10;
    localparam int RATE_W     = 16;
    localparam int HOLD_W     = 16;
    localparam int GAP_W      = 17;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int PROD_W     = RATE_W + DT_W;
    localparam int IDX_W      = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;

    localparam logic [LVL_W-1:0] Q16_ONE = LVL_W'(65536);
    localparam logic [AGE_W-1:0] AGE_MAX = '1;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_LVL_DECAY  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PK_DECAY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MARKER_GAP = 3'd4;

    localparam logic [RATE_W-1:0] LVL_DECAY_RST  = 16'd105;
    localparam logic [RATE_W-1:0] PK_DECAY_RST   = 16'd59;
    localparam logic [HOLD_W-1:0] HOLD_TIME_RST  = 16'd350;
    localparam logic [DT_W-1:0]   MAX_STEP_RST   = 10'd100;
    localparam logic [GAP_W-1:0]  MARKER_GAP_RST = 17'd6554;

    typedef struct packed {
        logic [RATE_W-1:0] lvl_decay;
        logic [RATE_W-1:0] pk_decay;
        logic [HOLD_W-1:0] hold_time;
        logic [DT_W-1:0]   max_step;
        logic [GAP_W-1:0]  marker_gap;
    } t_cfg;

    typedef struct packed {
        logic [LVL_W-1:0] level;
        logic [LVL_W-1:0] peak;
        logic [AGE_W-1:0] age;
    } t_band_state;

endpackage

@@ hw/rtl/peak_hold_band_meter.sv @@
// Peak-hold band meter: one ballistics update per word, one word per clock cycle sustained
// while results are taken. A word accepted on the input is captured in an input register;
// when the output register is empty or being emptied, the band's bar level, peak and peak
// age are read, updated and written back while the result moves to the output register.
// The per-band state lives in flip-flops and is read and rewritten in the cycle that the
// word leaves the input register, which lets back-to-back words for the same band see
// each other's results without stalls and sets the rate at one word per cycle. The output
// register holds a result until it is taken; the input side keeps accepting while one
// result waits and stalls only when both registers are full. Levels are unsigned Q16
// (65536 is 1.0), times are in milliseconds. The user must write configuration through
// the plain write port only while the block is idle; the block itself does not enforce it.
module peak_hold_band_meter
    import phbm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,

    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [BAND_W-1:0]     i_band,
    input  logic signed [TGT_W-1:0] i_target,
    input  logic [DT_W-1:0]       i_elapsed,

    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [BAND_W-1:0]     o_band_out,
    output logic [LVL_W-1:0]      o_level_out,
    output logic [LVL_W-1:0]      o_peak_out,
    output logic                  o_show_marker
);

    t_cfg cfg;

    // Input register.
    logic                r_s1_valid;
    logic [BAND_W-1:0]   r_s1_band;
    logic [TGT_W-1:0]    r_s1_target;
    logic [DT_W-1:0]     r_s1_elapsed;

    // Output register.
    logic                r_out_valid;
    logic [BAND_W-1:0]   r_out_band;
    logic [LVL_W-1:0]    r_out_level;
    logic [LVL_W-1:0]    r_out_peak;
    logic                r_out_marker;

    // Per-band state.
    t_band_state         r_state [NUM_BANDS];

    logic                s1_advance;
    logic                in_accept;
    logic                in_range;
    logic [IDX_W-1:0]    s1_idx;
    t_band_state         cur_state;
    t_band_state         upd_state;
    logic                upd_marker;

    phbm_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // The input register moves on whenever the output register is empty or being emptied.
    assign s1_advance = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_advance;
    assign in_accept  = i_in_valid && o_in_ready;

    // Bands beyond the state array leave the state alone and report zeros.
    assign in_range  = 32'(r_s1_band) < 32'(NUM_BANDS);
    assign s1_idx    = IDX_W'(r_s1_band);
    assign cur_state = r_state[s1_idx];

    phbm_update u_update (
        .i_cfg     (cfg),
        .i_target  (r_s1_target),
        .i_elapsed (r_s1_elapsed),
        .i_state   (cur_state),
        .o_state   (upd_state),
        .o_marker  (upd_marker)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_band    <= i_band;
            r_s1_target  <= i_target;
            r_s1_elapsed <= i_elapsed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_out_band <= r_s1_band;
            if (in_range) begin
                r_out_level  <= upd_state.level;
                r_out_peak   <= upd_state.peak;
                r_out_marker <= upd_marker;
            end else begin
                r_out_level  <= '0;
                r_out_peak   <= '0;
                r_out_marker <= 1'b0;
            end
        end
    end

    // The write-back lands at the same edge that the result is registered, so the next
    // word reads the updated entry directly.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_BANDS; i++) begin
                r_state[i] <= '0;
            end
        end else if (s1_advance && in_range) begin
            r_state[s1_idx] <= upd_state;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_band_out    = r_out_band;
    assign o_level_out   = r_out_level;
    assign o_peak_out    = r_out_peak;
    assign o_show_marker = r_out_marker;

endmodule

@@ hw/rtl/phbm_cfg.sv @@
module phbm_cfg
    import phbm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lvl_decay  <= LVL_DECAY_RST;
            r_cfg.pk_decay   <= PK_DECAY_RST;
            r_cfg.hold_time  <= HOLD_TIME_RST;
            r_cfg.max_step   <= MAX_STEP_RST;
            r_cfg.marker_gap <= MARKER_GAP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LVL_DECAY: begin
                    r_cfg.lvl_decay <= i_cfg_data[RATE_W-1:0];
                end
                REG_PK_DECAY: begin
                    r_cfg.pk_decay <= i_cfg_data[RATE_W-1:0];
                end
                REG_HOLD_TIME: begin
                    r_cfg.hold_time <= i_cfg_data[HOLD_W-1:0];
                end
                REG_MAX_STEP: begin
                    r_cfg.max_step <= i_cfg_data[DT_W-1:0];
                end
                REG_MARKER_GAP: begin
                    r_cfg.marker_gap <= i_cfg_data[GAP_W-1:0];
                end
                default: begin
                    // Writes beyond the register list are dropped.
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ hw/rtl/phbm_update.sv @@
module phbm_update
    import phbm_pkg::*;
(
    input  t_cfg                i_cfg,
    input  logic [TGT_W-1:0]    i_target,
    input  logic [DT_W-1:0]     i_elapsed,
    input  t_band_state         i_state,
    output t_band_state         o_state,
    output logic                o_marker
);

    logic [LVL_W-1:0]    tgt;
    logic [DT_W-1:0]     dt;
    logic [PROD_W-1:0]   lvl_drop;
    logic [PROD_W-1:0]   pk_drop;
    logic signed [PROD_W:0] lvl_fallen;
    logic signed [PROD_W:0] pk_fallen;
    logic [LVL_W-1:0]    new_lvl;
    logic [LVL_W-1:0]    new_pk;
    logic [AGE_W:0]      age_sum;
    logic [AGE_W-1:0]    age_sat;
    logic [AGE_W-1:0]    new_age;

    always_comb begin
        // Clamp the signed target into 0..1.0.
        if (i_target[TGT_W-1]) begin
            tgt = '0;
        end else if (i_target[TGT_W-2:0] > Q16_ONE) begin
            tgt = Q16_ONE;
        end else begin
            tgt = i_target[LVL_W-1:0];
        end

        dt = (i_elapsed > i_cfg.max_step) ? i_cfg.max_step : i_elapsed;

        // Both decay products use dt and a rate only, so they run side by side.
        lvl_drop = PROD_W'(i_cfg.lvl_decay) * PROD_W'(dt);
        pk_drop  = PROD_W'(i_cfg.pk_decay) * PROD_W'(dt);

        lvl_fallen = $signed({{(PROD_W + 1 - LVL_W){1'b0}}, i_state.level})
                   - $signed({1'b0, lvl_drop});
        if (tgt > i_state.level) begin
            new_lvl = tgt;
        end else if (lvl_fallen > $signed({{(PROD_W + 1 - LVL_W){1'b0}}, tgt})) begin
            new_lvl = lvl_fallen[LVL_W-1:0];
        end else begin
            new_lvl = tgt;
        end

        age_sum = {1'b0, i_state.age} + (AGE_W + 1)'(dt);
        age_sat = age_sum[AGE_W] ? AGE_MAX : age_sum[AGE_W-1:0];
        pk_fallen = $signed({{(PROD_W + 1 - LVL_W){1'b0}}, i_state.peak})
                  - $signed({1'b0, pk_drop});

        if (new_lvl >= i_state.peak) begin
            new_pk  = new_lvl;
            new_age = '0;
        end else begin
            new_age = age_sat;
            if (age_sat > i_cfg.hold_time) begin
                if (pk_fallen > $signed({{(PROD_W + 1 - LVL_W){1'b0}}, new_lvl})) begin
                    new_pk = pk_fallen[LVL_W-1:0];
                end else begin
                    new_pk = new_lvl;
                end
            end else begin
                new_pk = i_state.peak;
            end
        end

        o_state.level = new_lvl;
        o_state.peak  = new_pk;
        o_state.age   = new_age;
        o_marker = {1'b0, new_pk} > ({1'b0, new_lvl} + {1'b0, i_cfg.marker_gap});
    end

endmodule

@@ dv/phbm_tb_pkg.sv @@
`timescale 1ns / 1ps

package phbm_tb_pkg;
    import phbm_pkg::*;

    // One result word as the meter should present it.
    typedef struct {
        logic [BAND_W-1:0] band;
        logic [LVL_W-1:0]  level;
        logic [LVL_W-1:0]  peak;
        logic              marker;
    } t_meter_reading;

    class meter_ballistics_scoreboard;
        t_cfg           cfg;
        t_band_state    bands [NUM_BANDS];
        t_meter_reading expected_readings [$];
        int             words_seen;
        int             readings_checked;
        int             mismatches;

        function new();
            cfg.lvl_decay  = LVL_DECAY_RST;
            cfg.pk_decay   = PK_DECAY_RST;
            cfg.hold_time  = HOLD_TIME_RST;
            cfg.max_step   = MAX_STEP_RST;
            cfg.marker_gap = MARKER_GAP_RST;
            foreach (bands[i]) bands[i] = '0;
            words_seen       = 0;
            readings_checked = 0;
            mismatches       = 0;
        endfunction

        // Writes to indexes past the register list leave the settings alone.
        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_LVL_DECAY:  cfg.lvl_decay  = data[RATE_W-1:0];
                REG_PK_DECAY:   cfg.pk_decay   = data[RATE_W-1:0];
                REG_HOLD_TIME:  cfg.hold_time  = data[HOLD_W-1:0];
                REG_MAX_STEP:   cfg.max_step   = data[DT_W-1:0];
                REG_MARKER_GAP: cfg.marker_gap = data[GAP_W-1:0];
                default: ;
            endcase
        endfunction

        // Advances the ballistics of one band and queues the reading it yields.
        function void note_word(input logic [BAND_W-1:0] band,
                                input logic signed [TGT_W-1:0] target,
                                input logic [DT_W-1:0] elapsed);
            t_meter_reading r;
            longint         tgt;
            longint         lvl;
            longint         pk;
            longint         fallen;
            longint         age;
            longint         dt;
            words_seen++;
            r.band = band;
            if (int'(band) >= NUM_BANDS) begin
                r.level  = '0;
                r.peak   = '0;
                r.marker = 1'b0;
                expected_readings.push_back(r);
                return;
            end
            tgt = longint'(target);
            if (tgt < 0) tgt = 0;
            if (tgt > 65536) tgt = 65536;
            dt = elapsed;
            if (dt > cfg.max_step) dt = cfg.max_step;
            lvl = bands[band].level;
            pk  = bands[band].peak;
            age = bands[band].age;

            if (tgt > lvl) begin
                lvl = tgt;
            end else begin
                fallen = lvl - longint'(cfg.lvl_decay) * dt;
                lvl = (fallen > tgt) ? fallen : tgt;
            end

            if (lvl >= pk) begin
                pk  = lvl;
                age = 0;
            end else begin
                age = age + dt;
                if (age > 65535) age = 65535;
                if (age > cfg.hold_time) begin
                    fallen = pk - longint'(cfg.pk_decay) * dt;
                    pk = (fallen > lvl) ? fallen : lvl;
                end
            end

            bands[band].level = lvl[LVL_W-1:0];
            bands[band].peak  = pk[LVL_W-1:0];
            bands[band].age   = age[AGE_W-1:0];
            r.level  = lvl[LVL_W-1:0];
            r.peak   = pk[LVL_W-1:0];
            r.marker = (pk > lvl + longint'(cfg.marker_gap));
            expected_readings.push_back(r);
        endfunction

        function void check_reading(input logic [BAND_W-1:0] band,
                                    input logic [LVL_W-1:0] level,
                                    input logic [LVL_W-1:0] peak,
                                    input logic marker);
            t_meter_reading e;
            if (expected_readings.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected reading: band %0d level %0d peak %0d marker %0b",
                             band, level, peak, marker);
                return;
            end
            e = expected_readings.pop_front();
            readings_checked++;
            if (band !== e.band || level !== e.level || peak !== e.peak ||
                marker !== e.marker) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $write("mismatch: expected band %0d level %0d peak %0d marker %0b,",
                           e.band, e.level, e.peak, e.marker);
                    $display(" got band %0d level %0d peak %0d marker %0b",
                             band, level, peak, marker);
                end
            end
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction
    endclass

endpackage

@@ dv/peak_hold_band_meter_tb.sv @@
`timescale 1ns / 1ps

module peak_hold_band_meter_tb
    import phbm_pkg::*;
    import phbm_tb_pkg::*;
();

    // The watchdog limit is far above the slowest legal run, even with the
    // heaviest stalls on both sides.
    localparam int CYCLE_LIMIT  = 400000;
    // Settling time after the last reading before settings change or the run ends.
    localparam int DRAIN_CYCLES = 8;
    // First index past the register list; writes from here on must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = REG_MARKER_GAP + CFG_IDX_W'(1);

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data  = '0;
    logic                    i_in_valid  = 1'b0;
    logic                    o_in_ready;
    logic [BAND_W-1:0]       i_band      = '0;
    logic signed [TGT_W-1:0] i_target    = '0;
    logic [DT_W-1:0]         i_elapsed   = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic [BAND_W-1:0]       o_band_out;
    logic [LVL_W-1:0]        o_level_out;
    logic [LVL_W-1:0]        o_peak_out;
    logic                    o_show_marker;

    meter_ballistics_scoreboard sb;

    // Percent of cycles in which each side holds back.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count   = 0;
    int settings_done = 0;

    peak_hold_band_meter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_band        (i_band),
        .i_target      (i_target),
        .i_elapsed     (i_elapsed),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_band_out    (o_band_out),
        .o_level_out   (o_level_out),
        .o_peak_out    (o_peak_out),
        .o_show_marker (o_show_marker)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Output side. Values read right after the edge are the ones the block
    // presented at that edge, so a taken reading is checked here. Ready is then
    // redrawn for the next cycle, independent of whether a reading is waiting.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_reading(o_band_out, o_level_out, o_peak_out, o_show_marker);
        end
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles with %0d readings outstanding",
                 cycle_count, sb.pending());
        $display("peak_hold_band_meter test failed");
        $finish;
    end

    // Presents one input word and returns in the time step of the edge that
    // took it. The caller must call again (or drain) in that same step, so
    // valid is either kept high with a new payload or lowered exactly once.
    task automatic send_word(input logic [BAND_W-1:0] band,
                             input logic signed [TGT_W-1:0] target,
                             input logic [DT_W-1:0] elapsed);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_band     <= band;
        i_target   <= target;
        i_elapsed  <= elapsed;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_word(band, target, elapsed);
    endtask

    // Stops input and waits until every reading is back, plus settling time.
    task automatic drain_readings();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Leaves the write enable high; the caller lowers it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    // Writes the full register set while the meter is idle. The data is a full
    // port width wide, so the upper bits of the narrower registers get driven
    // and must be dropped. A stray write past the list goes in as well.
    task automatic apply_settings(input logic [CFG_DATA_W-1:0] lvl_dec,
                                  input logic [CFG_DATA_W-1:0] pk_dec,
                                  input logic [CFG_DATA_W-1:0] hold,
                                  input logic [CFG_DATA_W-1:0] step,
                                  input logic [CFG_DATA_W-1:0] gap);
        drain_readings();
        write_reg(REG_LVL_DECAY, lvl_dec);
        write_reg(REG_PK_DECAY, pk_dec);
        write_reg(REG_HOLD_TIME, hold);
        write_reg(REG_MAX_STEP, step);
        write_reg(REG_MARKER_GAP, gap);
        write_reg(REG_UNUSED_LO + CFG_IDX_W'($urandom_range(0, 2)),
                  CFG_DATA_W'($urandom));
        i_cfg_we <= 1'b0;
        settings_done++;
    endtask

    // Random traffic shaped like a meter feed: one band gets a quarter of the
    // words so its peak hold and decay run deep, targets are mostly quiet with
    // loud bursts, and a minority are out of range. Most elapsed times respect
    // the step limit; the rest span the whole field to hit saturation.
    task automatic random_words(input int count);
        logic [BAND_W-1:0]       hot;
        logic [BAND_W-1:0]       band;
        logic signed [TGT_W-1:0] target;
        logic [DT_W-1:0]         elapsed;
        int                      sel;
        hot = BAND_W'($urandom_range(0, NUM_BANDS - 1));
        for (int n = 0; n < count; n++) begin
            band = ($urandom_range(0, 3) == 0) ? hot : BAND_W'($urandom);
            sel = $urandom_range(0, 99);
            if (sel < 20)
                target = TGT_W'($urandom_range(32768, 65536));
            else if (sel < 70)
                target = TGT_W'($urandom_range(0, 8000));
            else if (sel < 80)
                target = $urandom_range(0, 1) ? TGT_W'(65536) : TGT_W'(0);
            else if (sel < 90)
                target = TGT_W'(-int'($urandom_range(1, 131072)));
            else
                target = TGT_W'($urandom_range(65537, 131071));
            if ($urandom_range(0, 4) != 0)
                elapsed = DT_W'($urandom_range(0, int'(sb.cfg.max_step)));
            else
                elapsed = DT_W'($urandom);
            send_word(band, target, elapsed);
        end
    endtask

    // Keeps one band's peak far above its level with long steps until the
    // peak age runs into its ceiling and, just past the hold time, the peak
    // drops onto the level in one step.
    task automatic age_ceiling_run();
        logic [BAND_W-1:0] band;
        band = BAND_W'($urandom_range(0, NUM_BANDS - 1));
        send_word(band, TGT_W'(65536), DT_W'(0));
        for (int n = 0; n < 72; n++) begin
            send_word(band, TGT_W'($urandom_range(0, 1000)), DT_W'(1023));
        end
    endtask

    initial begin
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sender idles lightly, receiver heavily.
        send_idle_pct = 25;
        recv_idle_pct = 61;

        // Directed words on the reset settings. Band 0 jumps to full scale,
        // then decays while its peak hangs past the hold time and starts to
        // fall; an over-long elapsed time gets cut back to the step limit.
        send_word(3'd0, TGT_W'(65536), DT_W'(0));
        send_word(3'd0, TGT_W'(0), DT_W'(100));
        send_word(3'd0, TGT_W'(0), DT_W'(1023));
        send_word(3'd0, TGT_W'(0), DT_W'(100));
        send_word(3'd0, TGT_W'(0), DT_W'(100));
        send_word(3'd0, TGT_W'(0), DT_W'(1023));
        // Targets outside 0..1.0 clamp at both ends, field extremes included.
        send_word(3'd1, TGT_W'(-131072), DT_W'(50));
        send_word(3'd1, TGT_W'(131071), DT_W'(50));
        send_word(3'd2, TGT_W'(65537), DT_W'(10));
        send_word(3'd2, TGT_W'(-1), DT_W'(10));
        // The decay stops at the target rather than undershooting it.
        send_word(3'd3, TGT_W'(30000), DT_W'(0));
        send_word(3'd3, TGT_W'(29000), DT_W'(0));
        send_word(3'd3, TGT_W'(29000), DT_W'(100));
        send_word(3'd3, TGT_W'(0), DT_W'(99));
        // Level equal to the held peak refreshes the peak.
        send_word(3'd4, TGT_W'(20000), DT_W'(5));
        send_word(3'd4, TGT_W'(20000), DT_W'(5));
        send_word(3'd5, TGT_W'(1), DT_W'(1));
        send_word(3'd5, TGT_W'(0), DT_W'(1023));
        send_word(3'd6, TGT_W'(0), DT_W'(0));
        send_word(3'd7, TGT_W'(65536), DT_W'(0));
        send_word(3'd7, TGT_W'(0), DT_W'(0));

        // Fully random register contents.
        apply_settings(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                       CFG_DATA_W'($urandom_range(0, 2000)), CFG_DATA_W'($urandom),
                       CFG_DATA_W'($urandom));
        random_words(130);

        // Zero rates freeze both decays, zero hold and gap, widest step.
        apply_settings('0, '0, '0, CFG_DATA_W'(1023), '0);
        random_words(110);

        // Receiver idles lightly, sender heavily.
        send_idle_pct = 61;
        recv_idle_pct = 25;

        // Every register at its top value; the marker gap is beyond 1.0 so
        // the marker can never show.
        apply_settings('1, '1, '1, '1, '1);
        random_words(100);

        // Peak age ceiling with the hold time just below it.
        apply_settings(CFG_DATA_W'(65535), CFG_DATA_W'(65535), CFG_DATA_W'(65534),
                       CFG_DATA_W'(1023), '0);
        age_ceiling_run();
        random_words(30);

        // No idling on either side.
        send_idle_pct = 0;
        recv_idle_pct = 0;

        // A step limit of zero pins elapsed time to nothing.
        apply_settings(CFG_DATA_W'($urandom_range(1, 200)),
                       CFG_DATA_W'($urandom_range(1, 200)),
                       CFG_DATA_W'($urandom_range(0, 400)), '0,
                       CFG_DATA_W'($urandom_range(0, 65536)));
        random_words(60);

        // Back to the power-on values, written explicitly.
        apply_settings(CFG_DATA_W'(LVL_DECAY_RST), CFG_DATA_W'(PK_DECAY_RST),
                       CFG_DATA_W'(HOLD_TIME_RST), CFG_DATA_W'(MAX_STEP_RST),
                       CFG_DATA_W'(MARKER_GAP_RST));
        random_words(110);

        drain_readings();

        $display("covered %0d input words and %0d checked readings over %0d register settings",
                 sb.words_seen, sb.readings_checked, settings_done);
        $display("three idle patterns, %0d mismatches, %0d readings never returned",
                 sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("peak_hold_band_meter test passed");
        end else begin
            $display("peak_hold_band_meter test failed");
        end
        $finish;
    end

endmodule
